// ===== src/lgs_pkg.sv =====
// Shared types and constants for the life grid generation step block.
package lgs_pkg;

  // Field widths fixed by the item format.
  localparam int OP_W      = 2;
  localparam int COORD_W   = 6;
  localparam int DIM_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int NBR_CNT_W = 4;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ    = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd1;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  // B3/S23 rule.
  localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_CNT_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               cell_in;
  } in_t;

  typedef struct packed {
    logic            cell_out;
    logic [OP_W-1:0] op_done;
  } out_t;

endpackage

// ===== src/life_grid_generation_step_core.sv =====
// Game of Life (B3/S23) grid engine with cell write, cell read and generation step.
//
// The grid is held in one synchronous memory of GRID_ROWS words, each a whole row of
// GRID_COLS cells, with one read and one write port. After reset a clearing pass writes
// every row dead, one row a cycle, and no item is taken until it ends. A write item is a
// read-modify-write of one row and a read item reads one row; an off-grid index or the
// unused op code is answered with no memory access. An advance sweeps the region one row
// a cycle, holding the pre-step rows above and at the update point in two row registers
// while the row below is read; an empty region is answered with no memory access. One
// item is worked on at a time; the result register lets the next item be taken while a
// result is still waiting.
module life_grid_generation_step_core #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,

  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  lgs_pkg::in_t                           in_data,

  output logic                                   out_valid,
  input  logic                                   out_stall,
  output lgs_pkg::out_t                          out_data,

  input  logic                                   cfg_we,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [lgs_pkg::DIM_W-1:0]              cfg_data
);

  localparam int RAW = $clog2(GRID_ROWS);
  localparam int CAW = $clog2(GRID_COLS);
  localparam int RCW = $clog2(GRID_ROWS+1);
  localparam int CCW = $clog2(GRID_COLS+1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW,
    S_GEN_FIRST,
    S_GEN_ROW,
    S_DONE
  } state_t;

  state_t                       state_r;
  logic [RAW-1:0]               clr_ctr_r;
  lgs_pkg::in_t                 item_r;
  logic                         cell_r;
  logic [RCW-1:0]               gen_row_r;
  logic [GRID_COLS-1:0]         prev_row_r;
  logic [GRID_COLS-1:0]         cur_row_r;
  logic                         out_valid_r;
  lgs_pkg::out_t                out_data_r;
  logic [lgs_pkg::DIM_W-1:0]    cols_in_use_r;
  logic [lgs_pkg::DIM_W-1:0]    rows_in_use_r;

  // grid memory
  logic [GRID_COLS-1:0]         grid_mem [GRID_ROWS];
  logic [GRID_COLS-1:0]         rd_data_r;
  logic                         rd_en;
  logic [RAW-1:0]               rd_addr;
  logic                         wr_en;
  logic [RAW-1:0]               wr_addr;
  logic [GRID_COLS-1:0]         wr_data;

  logic                         in_xfer;
  logic                         in_on_grid;
  logic                         item_on_grid;
  logic [CCW-1:0]               n_cols;
  logic [RCW-1:0]               n_rows;
  logic                         region_empty;
  logic                         r1_in;
  logic                         r2_in;
  logic [RCW:0]                 row_p1;
  logic [RCW:0]                 row_p2;
  logic [GRID_COLS-1:0]         rmw_row;
  logic [GRID_COLS-1:0]         new_row;
  logic                         out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign in_on_grid   = (32'(in_data.col) < GRID_COLS) && (32'(in_data.row) < GRID_ROWS);
  assign item_on_grid = (32'(item_r.col) < GRID_COLS) && (32'(item_r.row) < GRID_ROWS);

  // region size saturates at the grid size
  assign n_cols = (32'(cols_in_use_r) > GRID_COLS) ? CCW'(GRID_COLS) : CCW'(cols_in_use_r);
  assign n_rows = (32'(rows_in_use_r) > GRID_ROWS) ? RCW'(GRID_ROWS) : RCW'(rows_in_use_r);
  assign region_empty = (n_cols == '0) || (n_rows == '0);

  assign row_p1 = {1'b0, gen_row_r} + (RCW+1)'(1);
  assign row_p2 = {1'b0, gen_row_r} + (RCW+1)'(2);
  assign r1_in  = (row_p1 < {1'b0, n_rows});
  assign r2_in  = (row_p2 < {1'b0, n_rows});

  always_comb begin
    rmw_row = rd_data_r;
    rmw_row[CAW'(item_r.col)] = item_r.cell_in;
  end

  lgs_gen_row #(
    .GRID_COLS (GRID_COLS)
  ) u_gen_row (
    .prev_row  (prev_row_r),
    .prev_live (gen_row_r != '0),
    .cur_row   (cur_row_r),
    .next_row  (rd_data_r),
    .next_live (r1_in),
    .n_cols    (n_cols),
    .new_row   (new_row)
  );

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_ctr_r;
      end
      S_IDLE: begin
        if (in_xfer) begin
          if ((in_data.op == lgs_pkg::OP_WRITE || in_data.op == lgs_pkg::OP_READ) &&
              in_on_grid) begin
            rd_en   = 1'b1;
            rd_addr = RAW'(in_data.row);
          end else if (in_data.op == lgs_pkg::OP_ADVANCE && !region_empty) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end
      S_RMW: begin
        if (item_r.op == lgs_pkg::OP_WRITE) begin
          wr_en   = 1'b1;
          wr_addr = RAW'(item_r.row);
          wr_data = rmw_row;
        end
      end
      S_GEN_FIRST: begin
        if (r1_in) begin
          rd_en   = 1'b1;
          rd_addr = RAW'(row_p1);
        end
      end
      S_GEN_ROW: begin
        // row r is written while row r+2 is read; they never coincide
        wr_en   = 1'b1;
        wr_addr = RAW'(gen_row_r);
        wr_data = new_row;
        if (r2_in) begin
          rd_en   = 1'b1;
          rd_addr = RAW'(row_p2);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= grid_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_in_use_r <= lgs_pkg::DIM_RESET;
      rows_in_use_r <= lgs_pkg::DIM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == lgs_pkg::CFG_COLS_IN_USE) begin
        cols_in_use_r <= cfg_data;
      end else if (cfg_index == lgs_pkg::CFG_ROWS_IN_USE) begin
        rows_in_use_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_ctr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_DONE the result register is reloaded below whenever it drains
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_ctr_r <= clr_ctr_r + RAW'(1);
          if (clr_ctr_r == RAW'(GRID_ROWS-1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            item_r    <= in_data;
            cell_r    <= 1'b0;
            gen_row_r <= '0;
            if ((in_data.op == lgs_pkg::OP_WRITE || in_data.op == lgs_pkg::OP_READ) &&
                in_on_grid) begin
              state_r <= S_RMW;
            end else if (in_data.op == lgs_pkg::OP_ADVANCE && !region_empty) begin
              state_r <= S_GEN_FIRST;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_RMW: begin
          if (item_r.op == lgs_pkg::OP_READ && item_on_grid) begin
            cell_r <= rd_data_r[CAW'(item_r.col)];
          end
          state_r <= S_DONE;
        end
        S_GEN_FIRST: begin
          cur_row_r <= rd_data_r;
          state_r   <= S_GEN_ROW;
        end
        S_GEN_ROW: begin
          prev_row_r <= cur_row_r;
          cur_row_r  <= rd_data_r;
          gen_row_r  <= RCW'(row_p1);
          if (!r1_in) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r         <= 1'b1;
            out_data_r.cell_out <= cell_r;
            out_data_r.op_done  <= item_r.op;
            state_r             <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/lgs_gen_row.sv =====
// Next-generation logic for one grid row from the pre-step rows above, at and below it.
module lgs_gen_row #(
  parameter int GRID_COLS = 64
) (
  input  logic [GRID_COLS-1:0]             prev_row,
  input  logic                             prev_live,
  input  logic [GRID_COLS-1:0]             cur_row,
  input  logic [GRID_COLS-1:0]             next_row,
  input  logic                             next_live,
  input  logic [$clog2(GRID_COLS+1)-1:0]   n_cols,
  output logic [GRID_COLS-1:0]             new_row
);

  localparam int CCW = $clog2(GRID_COLS+1);

  logic [GRID_COLS-1:0] col_mask;
  logic [GRID_COLS-1:0] prev_m;
  logic [GRID_COLS-1:0] cur_m;
  logic [GRID_COLS-1:0] next_m;
  logic [GRID_COLS+1:0] prev_pad;
  logic [GRID_COLS+1:0] cur_pad;
  logic [GRID_COLS+1:0] next_pad;

  assign cur_m  = cur_row & col_mask;
  assign prev_m = prev_live ? (prev_row & col_mask) : '0;
  assign next_m = next_live ? (next_row & col_mask) : '0;

  // Dead border on both sides, so column c sits at pad bit c+1
  assign prev_pad = {1'b0, prev_m, 1'b0};
  assign cur_pad  = {1'b0, cur_m, 1'b0};
  assign next_pad = {1'b0, next_m, 1'b0};

  for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
    logic [lgs_pkg::NBR_CNT_W-1:0] cnt;
    logic                          life;

    assign col_mask[c] = (CCW'(c) < n_cols);

    assign cnt = {3'b000, prev_pad[c]} + {3'b000, prev_pad[c+1]} + {3'b000, prev_pad[c+2]}
               + {3'b000, cur_pad[c]}                             + {3'b000, cur_pad[c+2]}
               + {3'b000, next_pad[c]} + {3'b000, next_pad[c+1]} + {3'b000, next_pad[c+2]};

    assign life = (cnt == lgs_pkg::BIRTH_COUNT) ||
                  ((cnt == lgs_pkg::SURVIVE_COUNT) && cur_m[c]);

    // cells outside the region keep their value
    assign new_row[c] = col_mask[c] ? life : cur_row[c];
  end

endmodule
